// File: rtl/unique_prefix_keyword_lookup_assert.svh
// Assertion macros for the unique-prefix keyword lookup block.
`ifndef UNIQUE_PREFIX_KEYWORD_LOOKUP_ASSERT_SVH
`define UNIQUE_PREFIX_KEYWORD_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPKL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UPKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/upkl_pkg.sv
// Shared types and constants for the unique-prefix keyword lookup block.
package upkl_pkg;

    localparam int FUNC_W     = 1;
    localparam int ENTRY_W    = 5;
    localparam int POSITION_W = 4;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 6;
    localparam int STATUS_W   = 2;
    localparam int INDEX_W    = 5;
    localparam int CHARS_W    = 6;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;

    localparam logic [CHARS_W-1:0] POS_MAX = 6'd63;

    localparam logic [STATUS_W-1:0] ST_UNIQUE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_AMBIG  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOW  = 3'b010,
        S_HIGH = 3'b100
    } state_t;

endpackage

// File: rtl/unique_prefix_keyword_lookup.sv
// Unique-prefix keyword lookup: table memory, index walk sequencer and result register.
// A write word or a '!' / terminator / already-failed character is handled without an index walk.
// A narrowing character walks the index with low probes and then high probes, one table read per probe
// through the single memory read port.
// A result appears in the output register the cycle after its terminator is accepted.
// Reset clears the word state and entry_count; the table is undefined until written.
`include "unique_prefix_keyword_lookup_assert.svh"

module unique_prefix_keyword_lookup #(
    parameter int ENTRIES = 32,
    parameter int MAX_LEN = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [upkl_pkg::COUNT_W-1:0]      cfg_write_data,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [upkl_pkg::FUNC_W-1:0]       func,
    input  logic [upkl_pkg::ENTRY_W-1:0]      entry,
    input  logic [upkl_pkg::POSITION_W-1:0]   position,
    input  logic [upkl_pkg::BYTE_W-1:0]       byte_value,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [upkl_pkg::STATUS_W-1:0]     status,
    output logic [upkl_pkg::INDEX_W-1:0]      match_index,
    output logic [upkl_pkg::CHARS_W-1:0]      chars_used,
    output logic                              bang_seen
);

    localparam int DEPTH = ENTRIES * MAX_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(ENTRIES);
    localparam int NW    = IW + 1;

    logic [upkl_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [upkl_pkg::BYTE_W-1:0] rd_data_reg;

    upkl_pkg::state_t state_reg, state_next;

    logic [upkl_pkg::COUNT_W-1:0] entry_count_reg;
    logic [IW-1:0]                low_reg, low_next;
    logic [IW-1:0]                high_reg, high_next;
    logic [IW-1:0]                cmp_idx_reg, cmp_idx_next;
    logic [upkl_pkg::CHARS_W-1:0] pos_reg, pos_next;
    logic [upkl_pkg::CHARS_W-1:0] cmp_pos_reg, cmp_pos_next;
    logic [upkl_pkg::BYTE_W-1:0]  char_reg, char_next;
    logic                         nm_reg, nm_next;
    logic                         bang_reg, bang_next;

    logic                          res_valid_reg, res_valid_next;
    logic [upkl_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [upkl_pkg::INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [upkl_pkg::CHARS_W-1:0]  res_chars_reg, res_chars_next;
    logic                          res_bang_reg, res_bang_next;

    logic          item_accept;
    logic          out_take;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [IW-1:0] rd_idx;
    logic [AW-1:0] rd_addr;

    logic [NW-1:0]                n_clamp;
    logic [IW-1:0]                n_last;
    logic                         word_start;
    logic [IW-1:0]                eff_low;
    logic [IW-1:0]                eff_high;
    logic                         eff_nm;
    logic                         eff_bang;
    logic                         is_term;
    logic                         in_width;
    logic                         hit;
    logic [upkl_pkg::CHARS_W-1:0] pos_inc;

    assign out_take    = res_valid_reg && !result_stall;
    assign item_stall  = (state_reg != upkl_pkg::S_IDLE) || (res_valid_reg && result_stall);
    assign item_accept = item_valid && !item_stall;

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign match_index  = res_index_reg;
    assign chars_used   = res_chars_reg;
    assign bang_seen    = res_bang_reg;

    assign n_clamp  = (32'(entry_count_reg) > ENTRIES) ? NW'(ENTRIES) : NW'(entry_count_reg);
    assign n_last   = IW'(n_clamp - NW'(1));

    assign word_start = (pos_reg == '0);
    assign eff_low    = word_start ? '0 : low_reg;
    assign eff_high   = word_start ? n_last : high_reg;
    assign eff_nm     = word_start ? (n_clamp == '0) : nm_reg;
    assign eff_bang   = word_start ? 1'b0 : bang_reg;

    assign is_term  = (byte_value == upkl_pkg::CH_NUL) || (byte_value == upkl_pkg::CH_COMMA)
                   || (byte_value == upkl_pkg::CH_SPACE);
    assign in_width = (32'(pos_reg) < MAX_LEN);
    assign pos_inc  = (pos_reg == upkl_pkg::POS_MAX) ? pos_reg
                                                     : pos_reg + upkl_pkg::CHARS_W'(1);
    assign hit      = (rd_data_reg == char_reg);

    assign wr_en   = item_accept && (func == upkl_pkg::FUNC_WRITE)
                  && (32'(entry) < ENTRIES) && (32'(position) < MAX_LEN);
    assign wr_addr = AW'(AW'(entry) * AW'(MAX_LEN) + AW'(position));
    assign rd_addr = AW'(AW'(rd_idx) * AW'(MAX_LEN) + AW'(cmp_pos_next));

    always_comb
    begin
        state_next      = state_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        cmp_idx_next    = cmp_idx_reg;
        pos_next        = pos_reg;
        cmp_pos_next    = cmp_pos_reg;
        char_next       = char_reg;
        nm_next         = nm_reg;
        bang_next       = bang_reg;
        res_valid_next  = out_take ? 1'b0 : res_valid_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_chars_next  = res_chars_reg;
        res_bang_next   = res_bang_reg;
        rd_en           = 1'b0;
        rd_idx          = cmp_idx_reg;

        unique case (state_reg)
            upkl_pkg::S_IDLE:
            begin
                if (item_accept && (func == upkl_pkg::FUNC_QUERY))
                begin
                    if (is_term)
                    begin
                        res_valid_next = 1'b1;
                        res_chars_next = pos_reg;
                        res_bang_next  = eff_bang;
                        res_index_next = '0;
                        if (eff_nm)
                        begin
                            res_status_next = upkl_pkg::ST_NONE;
                        end
                        else if (eff_low == eff_high)
                        begin
                            res_status_next = upkl_pkg::ST_UNIQUE;
                            res_index_next  = upkl_pkg::INDEX_W'(eff_low);
                        end
                        else
                        begin
                            res_status_next = upkl_pkg::ST_AMBIG;
                        end
                        pos_next  = '0;
                        nm_next   = 1'b0;
                        bang_next = 1'b0;
                    end
                    else
                    begin
                        low_next  = eff_low;
                        high_next = eff_high;
                        nm_next   = eff_nm;
                        bang_next = eff_bang;
                        pos_next  = pos_inc;
                        if (byte_value == upkl_pkg::CH_BANG)
                        begin
                            bang_next = 1'b1;
                        end
                        else if (!eff_nm)
                        begin
                            if (!in_width)
                            begin
                                nm_next = 1'b1;
                            end
                            else
                            begin
                                cmp_pos_next = pos_reg;
                                char_next    = byte_value;
                                cmp_idx_next = eff_low;
                                rd_idx       = eff_low;
                                rd_en        = 1'b1;
                                state_next   = upkl_pkg::S_LOW;
                            end
                        end
                    end
                end
            end

            upkl_pkg::S_LOW:
            begin
                if (hit)
                begin
                    low_next     = cmp_idx_reg;
                    cmp_idx_next = high_reg;
                    rd_idx       = high_reg;
                    rd_en        = 1'b1;
                    state_next   = upkl_pkg::S_HIGH;
                end
                else if (cmp_idx_reg == high_reg)
                begin
                    nm_next    = 1'b1;
                    state_next = upkl_pkg::S_IDLE;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + IW'(1);
                    rd_idx       = cmp_idx_reg + IW'(1);
                    rd_en        = 1'b1;
                end
            end

            upkl_pkg::S_HIGH:
            begin
                if (hit)
                begin
                    high_next  = cmp_idx_reg;
                    state_next = upkl_pkg::S_IDLE;
                end
                else if (cmp_idx_reg == low_reg)
                begin
                    nm_next    = 1'b1;
                    state_next = upkl_pkg::S_IDLE;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg - IW'(1);
                    rd_idx       = cmp_idx_reg - IW'(1);
                    rd_en        = 1'b1;
                end
            end

            default:
            begin
                state_next = upkl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= byte_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= upkl_pkg::S_IDLE;
            entry_count_reg <= '0;
            low_reg         <= '0;
            high_reg        <= '0;
            pos_reg         <= '0;
            nm_reg          <= 1'b0;
            bang_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            pos_reg       <= pos_next;
            nm_reg        <= nm_next;
            bang_reg      <= bang_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write_en)
            begin
                entry_count_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        cmp_pos_reg    <= cmp_pos_next;
        char_reg       <= char_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_chars_reg  <= res_chars_next;
        res_bang_reg   <= res_bang_next;
    end

    `UPKL_ASSERT_IMPLY(a_busy_stalls, clk, rst_n, state_reg != upkl_pkg::S_IDLE, item_stall, "input accepted during index walk")
    `UPKL_ASSERT_IMPLY(a_low_in_range, clk, rst_n, state_reg == upkl_pkg::S_LOW, (low_reg <= cmp_idx_reg) && (cmp_idx_reg <= high_reg), "low probe outside range")
    `UPKL_ASSERT_IMPLY(a_high_in_range, clk, rst_n, state_reg == upkl_pkg::S_HIGH, (low_reg <= cmp_idx_reg) && (cmp_idx_reg <= high_reg), "high probe outside range")
    `UPKL_ASSERT_IMPLY(a_walk_live, clk, rst_n, state_reg != upkl_pkg::S_IDLE, !nm_reg, "index walk on a failed word")
    `UPKL_ASSERT_NEXT(a_walk_no_result, clk, rst_n, (state_reg != upkl_pkg::S_IDLE) && !res_valid_reg, !res_valid_reg, "result raised by index walk")

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the keyword lookup block: loads sorted keywords, runs words, checks every result.
module tb_top;

    localparam int ENTRIES      = 32;
    localparam int MAX_LEN      = 16;
    localparam int TAB_AW       = $clog2(ENTRIES * MAX_LEN);
    localparam int WORD_IW      = $clog2(ENTRIES);
    localparam int BIT_W        = $clog2(MAX_LEN * upkl_pkg::BYTE_W);
    localparam int DRAIN_CYCLES = ENTRIES + 8;
    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASES       = 8;

    typedef struct packed {
        logic [upkl_pkg::STATUS_W-1:0] status;
        logic [upkl_pkg::INDEX_W-1:0]  index;
        logic [upkl_pkg::CHARS_W-1:0]  chars;
        logic                          bang;
    } match_result_t;

    logic                            clk            = 1'b0;
    logic                            rst_n          = 1'b0;
    logic                            cfg_write_en   = 1'b0;
    logic [upkl_pkg::COUNT_W-1:0]    cfg_write_data = '0;
    logic                            item_valid     = 1'b0;
    logic                            item_stall;
    logic [upkl_pkg::FUNC_W-1:0]     func           = upkl_pkg::FUNC_WRITE;
    logic [upkl_pkg::ENTRY_W-1:0]    entry          = '0;
    logic [upkl_pkg::POSITION_W-1:0] position       = '0;
    logic [upkl_pkg::BYTE_W-1:0]     byte_value     = '0;
    logic                            result_valid;
    logic                            result_stall   = 1'b0;
    logic [upkl_pkg::STATUS_W-1:0]   status;
    logic [upkl_pkg::INDEX_W-1:0]    match_index;
    logic [upkl_pkg::CHARS_W-1:0]    chars_used;
    logic                            bang_seen;

    // shadow of the block: keyword table, entry count and word state
    logic [upkl_pkg::BYTE_W-1:0]  table_mem [ENTRIES*MAX_LEN];
    logic [upkl_pkg::COUNT_W-1:0] keyword_count = '0;
    logic [upkl_pkg::INDEX_W-1:0] low_idx       = '0;
    logic [upkl_pkg::INDEX_W-1:0] high_idx      = '0;
    logic [upkl_pkg::CHARS_W-1:0] word_pos      = '0;
    logic                         miss_flag     = 1'b0;
    logic                         bang_flag     = 1'b0;

    match_result_t expected_matches[$];
    int mismatch_count  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    unique_prefix_keyword_lookup #(
        .ENTRIES(ENTRIES),
        .MAX_LEN(MAX_LEN)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .func          (func),
        .entry         (entry),
        .position      (position),
        .byte_value    (byte_value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .match_index   (match_index),
        .chars_used    (chars_used),
        .bang_seen     (bang_seen)
    );

    always #4 clk = ~clk;

    function automatic logic is_terminator(logic [upkl_pkg::BYTE_W-1:0] c);
        return (c == upkl_pkg::CH_NUL) || (c == upkl_pkg::CH_COMMA)
            || (c == upkl_pkg::CH_SPACE);
    endfunction

    function automatic logic [upkl_pkg::BYTE_W-1:0] table_at(logic [upkl_pkg::INDEX_W-1:0] e,
                                                             logic [upkl_pkg::CHARS_W-1:0] p);
        if (p >= MAX_LEN)
        begin
            return '0;
        end
        return table_mem[TAB_AW'(e*MAX_LEN + p)];
    endfunction

    function automatic int keyword_length(int k);
        int n;
        n = 0;
        while (n < MAX_LEN && table_mem[TAB_AW'(k*MAX_LEN + n)] != 8'h00)
        begin
            n++;
        end
        return n;
    endfunction

    function automatic void begin_word();
        logic [upkl_pkg::COUNT_W-1:0] n;
        n = (keyword_count > ENTRIES) ? upkl_pkg::COUNT_W'(ENTRIES) : keyword_count;
        low_idx   = '0;
        high_idx  = (n == 0) ? '0 : upkl_pkg::INDEX_W'(n - 1);
        miss_flag = (n == 0);
        bang_flag = 1'b0;
    endfunction

    function automatic void narrow_range(logic [upkl_pkg::BYTE_W-1:0] c);
        while (table_at(low_idx, word_pos) != c)
        begin
            if (low_idx == high_idx)
            begin
                miss_flag = 1'b1;
                return;
            end
            low_idx++;
        end
        while (table_at(high_idx, word_pos) != c)
        begin
            if (low_idx == high_idx)
            begin
                miss_flag = 1'b1;
                return;
            end
            high_idx--;
        end
    endfunction

    // advance the shadow by one accepted item; queue a result on a terminator
    function automatic void advance_lookup(logic [upkl_pkg::FUNC_W-1:0] f,
                                           logic [upkl_pkg::ENTRY_W-1:0] e,
                                           logic [upkl_pkg::POSITION_W-1:0] p,
                                           logic [upkl_pkg::BYTE_W-1:0] c);
        match_result_t r;
        if (f == upkl_pkg::FUNC_WRITE)
        begin
            table_mem[TAB_AW'(e*MAX_LEN + p)] = c;
            return;
        end
        if (word_pos == 0)
        begin
            begin_word();
        end
        if (is_terminator(c))
        begin
            r.index = '0;
            if (miss_flag)
            begin
                r.status = upkl_pkg::ST_NONE;
            end
            else if (low_idx == high_idx)
            begin
                r.status = upkl_pkg::ST_UNIQUE;
                r.index  = low_idx;
            end
            else
            begin
                r.status = upkl_pkg::ST_AMBIG;
            end
            r.chars = word_pos;
            r.bang  = bang_flag;
            expected_matches.push_back(r);
            word_pos  = '0;
            miss_flag = 1'b0;
            bang_flag = 1'b0;
            return;
        end
        if (c == upkl_pkg::CH_BANG)
        begin
            bang_flag = 1'b1;
        end
        else if (!miss_flag)
        begin
            narrow_range(c);
        end
        if (word_pos < upkl_pkg::POS_MAX)
        begin
            word_pos++;
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t MISMATCH %s: expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        match_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_matches.size() == 0)
            begin
                $display("%0t MISMATCH unexpected result: expected none, got status %0d index %0d",
                         $time, status, match_index);
                mismatch_count++;
            end
            else
            begin
                want = expected_matches.pop_front();
                results_checked++;
                check_field("status", 8'(want.status), 8'(status));
                check_field("match_index", 8'(want.index), 8'(match_index));
                check_field("chars_used", 8'(want.chars), 8'(chars_used));
                check_field("bang_seen", 8'(want.bang), 8'(bang_seen));
            end
        end
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_item(input logic [upkl_pkg::FUNC_W-1:0] f,
                             input logic [upkl_pkg::ENTRY_W-1:0] e,
                             input logic [upkl_pkg::POSITION_W-1:0] p,
                             input logic [upkl_pkg::BYTE_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        func       <= f;
        entry      <= e;
        position   <= p;
        byte_value <= c;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        advance_lookup(f, e, p, c);
        items_sent++;
    endtask

    task automatic send_query(input logic [upkl_pkg::BYTE_W-1:0] c);
        send_item(upkl_pkg::FUNC_QUERY, upkl_pkg::ENTRY_W'($urandom),
                  upkl_pkg::POSITION_W'($urandom), c);
    endtask

    task automatic send_write(input int e, input int p, input logic [upkl_pkg::BYTE_W-1:0] c);
        send_item(upkl_pkg::FUNC_WRITE, upkl_pkg::ENTRY_W'(e), upkl_pkg::POSITION_W'(p), c);
    endtask

    // rewrite one table byte: mostly with its current value, which keeps the sort order
    task automatic table_touch();
        int e;
        int p;
        e = $urandom_range(ENTRIES - 1);
        p = $urandom_range(MAX_LEN - 1);
        if ($urandom_range(3) == 0)
        begin
            send_write(e, p, upkl_pkg::BYTE_W'($urandom_range(255)));
        end
        else
        begin
            send_write(e, p, table_mem[TAB_AW'(e*MAX_LEN + p)]);
        end
    endtask

    task automatic send_prefix(input int k, input int len, input int bang_at, input int write_at);
        for (int i = 0; i < len; i++)
        begin
            if (i == write_at)
            begin
                table_touch();
            end
            send_query((i == bang_at) ? upkl_pkg::CH_BANG
                                      : table_at(upkl_pkg::INDEX_W'(k), upkl_pkg::CHARS_W'(i)));
        end
    endtask

    function automatic logic [upkl_pkg::BYTE_W-1:0] random_char();
        logic [upkl_pkg::BYTE_W-1:0] c;
        c = upkl_pkg::BYTE_W'($urandom_range(255));
        while (is_terminator(c))
        begin
            c = upkl_pkg::BYTE_W'($urandom_range(255));
        end
        return c;
    endfunction

    function automatic logic [upkl_pkg::BYTE_W-1:0] pick_terminator();
        case ($urandom_range(2))
            0: return upkl_pkg::CH_NUL;
            1: return upkl_pkg::CH_COMMA;
            default: return upkl_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic logic [upkl_pkg::BYTE_W-1:0] keyword_char();
        case ($urandom_range(15))
            0: return 8'hFF;
            1: return upkl_pkg::BYTE_W'($urandom_range(8'hFE, 8'h80));
            default: return 8'h61 + upkl_pkg::BYTE_W'($urandom_range(3));
        endcase
    endfunction

    // drop valid, wait out every result and let the block go quiet
    task automatic settle();
        item_valid <= 1'b0;
        while (expected_matches.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_entry_count(input logic [upkl_pkg::COUNT_W-1:0] n);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= n;
        @(posedge clk);
        cfg_write_en  <= 1'b0;
        keyword_count = n;
        @(posedge clk);
    endtask

    task automatic send_random_word();
        int pick;
        int k;
        int n_eff;
        int span;
        int len;
        int total;
        int bang_at;
        int write_at;
        logic all_bang;
        n_eff = (keyword_count > ENTRIES) ? ENTRIES : keyword_count;
        k     = (n_eff > 0) ? $urandom_range(n_eff - 1) : $urandom_range(ENTRIES - 1);
        span  = keyword_length(k);
        pick  = $urandom_range(99);
        if (pick < 50)
        begin
            len      = (span == 0) ? 0 : $urandom_range(span, 1);
            bang_at  = ($urandom_range(3) == 0 && len > 0) ? $urandom_range(len - 1) : -1;
            write_at = ($urandom_range(7) == 0 && len > 0) ? $urandom_range(len - 1) : -1;
            send_prefix(k, len, bang_at, write_at);
        end
        else if (pick < 62)
        begin
            send_prefix(k, span, -1, -1);
            repeat ($urandom_range(3, 1)) send_query(8'h61 + upkl_pkg::BYTE_W'($urandom_range(3)));
        end
        else if (pick < 77)
        begin
            send_prefix(k, $urandom_range(span), -1, -1);
            send_query(random_char());
            repeat ($urandom_range(3))
                send_query(($urandom_range(4) == 0) ? upkl_pkg::CH_BANG : random_char());
        end
        else if (pick < 87)
        begin
            repeat ($urandom_range(6)) send_query(random_char());
        end
        else if (pick < 94)
        begin
            len      = $urandom_range(span);
            total    = $urandom_range(72, 60);
            all_bang = 1'($urandom_range(1));
            send_prefix(k, len, -1, -1);
            for (int i = len; i < total; i++)
            begin
                send_query(all_bang ? upkl_pkg::CH_BANG : random_char());
            end
        end
        else
        begin
            repeat ($urandom_range(3, 1)) table_touch();
        end
        if (pick < 94)
        begin
            send_query(pick_terminator());
        end
    endtask

    task automatic test_empty_table();
        send_query(upkl_pkg::CH_NUL);
        send_query(upkl_pkg::CH_BANG);
        send_query(upkl_pkg::CH_COMMA);
        send_query(8'h61);
        send_query(8'h62);
        send_query(upkl_pkg::CH_SPACE);
    endtask

    task automatic test_load_table();
        logic [MAX_LEN*upkl_pkg::BYTE_W-1:0] words [ENTRIES];
        logic [MAX_LEN*upkl_pkg::BYTE_W-1:0] cur;
        logic [MAX_LEN*upkl_pkg::BYTE_W-1:0] swap;
        int keep;
        int len;
        settle();
        write_entry_count(upkl_pkg::COUNT_W'(ENTRIES));
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        for (int k = 0; k < ENTRIES; k++)
        begin
            cur  = '0;
            keep = 0;
            if (k > 0 && k != ENTRIES / 2 && $urandom_range(2) != 0)
            begin
                cur  = words[WORD_IW'($urandom_range(k - 1))];
                keep = $urandom_range(4);
            end
            len = (k == ENTRIES / 2) ? MAX_LEN : $urandom_range(9, 1);
            for (int i = 0; i < MAX_LEN; i++)
            begin
                if (i >= keep)
                begin
                    cur[BIT_W'((MAX_LEN-1-i)*upkl_pkg::BYTE_W) +: upkl_pkg::BYTE_W] =
                        (i < len) ? keyword_char() : 8'h00;
                end
            end
            words[WORD_IW'(k)] = cur;
        end
        // first character sits in the top byte, so a numeric sort is a dictionary sort
        for (int a = 0; a < ENTRIES - 1; a++)
        begin
            for (int b = 0; b < ENTRIES - 1 - a; b++)
            begin
                if (words[WORD_IW'(b)] > words[WORD_IW'(b+1)])
                begin
                    swap                 = words[WORD_IW'(b)];
                    words[WORD_IW'(b)]   = words[WORD_IW'(b+1)];
                    words[WORD_IW'(b+1)] = swap;
                end
            end
        end
        for (int k = 0; k < ENTRIES; k++)
        begin
            cur = words[WORD_IW'(k)];
            for (int p = 0; p < MAX_LEN; p++)
            begin
                send_write(k, p, cur[BIT_W'((MAX_LEN-1-p)*upkl_pkg::BYTE_W) +: upkl_pkg::BYTE_W]);
            end
        end
    endtask

    task automatic test_directed_words();
        int full_k;
        full_k = 0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (keyword_length(k) == MAX_LEN)
            begin
                full_k = k;
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_query(upkl_pkg::CH_SPACE);
        send_prefix(0, 1, -1, -1);
        send_query(upkl_pkg::CH_COMMA);
        send_prefix(full_k, 3, 0, -1);
        send_query(upkl_pkg::CH_SPACE);
        send_query(8'h7F);
        send_query(upkl_pkg::CH_BANG);
        send_query(8'h61);
        send_query(upkl_pkg::CH_NUL);
        // full-width keyword with a table write in the middle, then run past its width
        send_prefix(full_k, MAX_LEN, -1, 2);
        send_query(8'h62);
        send_query(upkl_pkg::CH_COMMA);
        settle();
        write_entry_count(upkl_pkg::COUNT_W'(1));
        send_query(upkl_pkg::CH_COMMA);
        send_query(8'hFF);
        send_query(upkl_pkg::CH_NUL);
    endtask

    task automatic test_random_phases();
        logic [upkl_pkg::COUNT_W-1:0] n;
        int target;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0: n = upkl_pkg::COUNT_W'(ENTRIES);
                1: n = upkl_pkg::COUNT_W'(63);
                2: n = upkl_pkg::COUNT_W'(1);
                3: n = upkl_pkg::COUNT_W'(2);
                4: n = upkl_pkg::COUNT_W'(0);
                5: n = upkl_pkg::COUNT_W'(ENTRIES - 1);
                6: n = upkl_pkg::COUNT_W'($urandom_range(ENTRIES - 2, 3));
                default: n = upkl_pkg::COUNT_W'($urandom_range(63, ENTRIES + 1));
            endcase
            write_entry_count(n);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
            begin
                send_random_word();
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_load_table();
        test_directed_words();
        test_random_phases();
        settle();
        $display("Sent %0d words (table loads, rewrites, query characters), checked %0d results,",
                 items_sent, results_checked);
        $display("entry counts from 0 to 63 under four sender/receiver idle patterns.");
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("%0t timeout with %0d results outstanding", $time, expected_matches.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
